// File: design/modexp_pkg.sv
// Shared types, widths and codes for the modular exponentiation core.
package modexp_pkg;

    localparam int MOD_BITS  = 31;
    localparam int EXP_BITS  = 31;
    localparam int BASE_BITS = 63;
    localparam int CFG_W     = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = $clog2(BASE_BITS);
    localparam int MUL_IDX_W = $clog2(MOD_BITS);
    localparam int EBIT_W    = $clog2(EXP_BITS);

    typedef logic [MOD_BITS-1:0]  t_mod;
    typedef logic [EXP_BITS-1:0]  t_exp;
    typedef logic [BASE_BITS-1:0] t_base;
    typedef logic [CFG_W-1:0]     t_cfg_data;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_EXPONENT = t_cfg_idx'(0);
    localparam t_cfg_idx REG_MODULUS  = t_cfg_idx'(1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SQR  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // Control of the shared modular double-and-add step.
    typedef struct packed {
        logic add_en;
        t_mod addend;
    } t_step_ctl;

endpackage

// File: design/modexp_if.sv
// Valid/ready stream interfaces for the base and power channels.
interface modexp_base_if;
    logic                 valid;
    logic                 ready;
    modexp_pkg::t_base    base;

    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);
endinterface

interface modexp_power_if;
    logic                 valid;
    logic                 ready;
    modexp_pkg::t_mod     power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

// File: design/modular_exponentiation_core.sv
// Modular exponentiation core, right-to-left square-and-multiply, one double-and-add unit.
// The base is reduced first; then per exponent bit a multiply when the bit is set, then a
// squaring; then the result is loaded into the output register once it is free. With a
// modulus below two the steps are skipped and the result is zero. One item at a time, one
// multiplier bit per cycle; the next base is taken the cycle after the result is loaded.
// Reset (synchronous) sets exponent to 1, modulus to 2 and empties the output register.
module modular_exponentiation_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  modexp_pkg::t_cfg_idx     i_cfg_idx,
    input  modexp_pkg::t_cfg_data    i_cfg_data,
    modexp_base_if.sink              i_base,
    modexp_power_if.source           o_power
);

    modexp_pkg::t_state     r_state, n_state;
    modexp_pkg::t_exp       r_exp;
    modexp_pkg::t_mod       r_mod;
    logic [modexp_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [modexp_pkg::EBIT_W-1:0] r_ebit, n_ebit;
    modexp_pkg::t_base      r_base, n_base;
    modexp_pkg::t_mod       r_acc, n_acc;
    modexp_pkg::t_mod       r_run, n_run;
    modexp_pkg::t_mod       r_prod, n_prod;
    logic                   r_out_valid, n_out_valid;
    modexp_pkg::t_mod       r_out_power, n_out_power;

    modexp_pkg::t_step_ctl  w_ctl;
    modexp_pkg::t_mod       w_step;
    logic                   w_last;
    logic                   w_in_acc;
    logic                   w_out_acc;

    assign i_base.ready  = (r_state == modexp_pkg::S_IDLE);
    assign o_power.valid = r_out_valid;
    assign o_power.power = r_out_power;
    assign w_in_acc      = i_base.valid && i_base.ready;
    assign w_out_acc     = r_out_valid && o_power.ready;
    assign w_last        = (r_cnt == '0);

    // Feed the base in MSB first with addend 1, or a multiplier bit of run.
    always_comb begin
        if (r_state == modexp_pkg::S_RED) begin
            w_ctl.add_en = r_base[r_cnt];
            w_ctl.addend = modexp_pkg::t_mod'(1);
        end else begin
            w_ctl.add_en = r_run[r_cnt[modexp_pkg::MUL_IDX_W-1:0]];
            w_ctl.addend = (r_state == modexp_pkg::S_MUL) ? r_acc : r_run;
        end
    end

    modexp_step u_step (
        .i_acc (r_prod),
        .i_ctl (w_ctl),
        .i_mod (r_mod),
        .o_acc (w_step)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_ebit      = r_ebit;
        n_base      = r_base;
        n_acc       = r_acc;
        n_run       = r_run;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_power = r_out_power;
        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            modexp_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_base = i_base.base;
                    if (r_mod < modexp_pkg::t_mod'(2)) begin
                        n_acc   = '0;
                        n_state = modexp_pkg::S_DONE;
                    end else begin
                        n_prod  = '0;
                        n_cnt   = modexp_pkg::CNT_W'(modexp_pkg::BASE_BITS - 1);
                        n_state = modexp_pkg::S_RED;
                    end
                end
            end
            modexp_pkg::S_RED: begin
                n_prod = w_step;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    n_run   = w_step;
                    n_acc   = modexp_pkg::t_mod'(1);
                    n_ebit  = '0;
                    n_prod  = '0;
                    n_cnt   = modexp_pkg::CNT_W'(modexp_pkg::MOD_BITS - 1);
                    n_state = r_exp[0] ? modexp_pkg::S_MUL : modexp_pkg::S_SQR;
                end
            end
            modexp_pkg::S_MUL: begin
                n_prod = w_step;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    n_acc   = w_step;
                    n_prod  = '0;
                    n_cnt   = modexp_pkg::CNT_W'(modexp_pkg::MOD_BITS - 1);
                    n_state = modexp_pkg::S_SQR;
                end
            end
            modexp_pkg::S_SQR: begin
                n_prod = w_step;
                n_cnt  = r_cnt - 1'b1;
                if (w_last) begin
                    n_run = w_step;
                    if (r_ebit == modexp_pkg::EBIT_W'(modexp_pkg::EXP_BITS - 1)) begin
                        n_state = modexp_pkg::S_DONE;
                    end else begin
                        n_ebit  = r_ebit + 1'b1;
                        n_prod  = '0;
                        n_cnt   = modexp_pkg::CNT_W'(modexp_pkg::MOD_BITS - 1);
                        n_state = r_exp[n_ebit] ? modexp_pkg::S_MUL : modexp_pkg::S_SQR;
                    end
                end
            end
            modexp_pkg::S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || o_power.ready) begin
                    n_out_valid = 1'b1;
                    n_out_power = r_acc;
                    n_state     = modexp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = modexp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= modexp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_exp       <= modexp_pkg::t_exp'(1);
            r_mod       <= modexp_pkg::t_mod'(2);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    modexp_pkg::REG_EXPONENT: r_exp <= i_cfg_data[modexp_pkg::EXP_BITS-1:0];
                    modexp_pkg::REG_MODULUS:  r_mod <= i_cfg_data[modexp_pkg::MOD_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_ebit      <= n_ebit;
        r_base      <= n_base;
        r_acc       <= n_acc;
        r_run       <= n_run;
        r_prod      <= n_prod;
        r_out_power <= n_out_power;
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != modexp_pkg::S_IDLE) |-> !i_base.ready)
        else $error("base accepted while busy");

    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == modexp_pkg::S_RED || r_state == modexp_pkg::S_MUL ||
         r_state == modexp_pkg::S_SQR) |-> (r_prod < r_mod))
        else $error("partial product not reduced");

    a_power_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_mod >= modexp_pkg::t_mod'(2)) |-> (r_out_power < r_mod))
        else $error("power not below modulus");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == modexp_pkg::S_DONE))
        else $error("result loaded outside done state");

endmodule

// File: design/modexp_step.sv
// Shared modular step: (2*r + bit*a) mod m for r, a below m.
module modexp_step (
    input  modexp_pkg::t_mod      i_acc,
    input  modexp_pkg::t_step_ctl i_ctl,
    input  modexp_pkg::t_mod      i_mod,
    output modexp_pkg::t_mod      o_acc
);

    localparam int SW = modexp_pkg::MOD_BITS + 2;

    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_m1;
    logic [SW-1:0] w_m2;
    logic [SW:0]   w_d1;
    logic [SW:0]   w_d2;

    // Sum stays below 3m, so one of three candidates is the residue.
    assign w_sum = {1'b0, i_acc, 1'b0}
                 + (i_ctl.add_en ? {2'b00, i_ctl.addend} : {SW{1'b0}});
    assign w_m1  = {2'b00, i_mod};
    assign w_m2  = {1'b0, i_mod, 1'b0};
    assign w_d1  = {1'b0, w_sum} - {1'b0, w_m1};
    assign w_d2  = {1'b0, w_sum} - {1'b0, w_m2};

    always_comb begin
        if (!w_d2[SW]) begin
            o_acc = w_d2[modexp_pkg::MOD_BITS-1:0];
        end else if (!w_d1[SW]) begin
            o_acc = w_d1[modexp_pkg::MOD_BITS-1:0];
        end else begin
            o_acc = w_sum[modexp_pkg::MOD_BITS-1:0];
        end
    end

endmodule
